FILE: sv/tsq_pkg.sv
`timescale 1ns / 1ps
package tsq_pkg;
    localparam int PRICE_BITS = 32;
    localparam int ID_BITS = 32;
    localparam int VOL_BITS = 24;
    localparam int CNT_BITS = $clog2(PRICE_BITS + 2);

    localparam logic [1:0] K_THEO = 2'd0;
    localparam logic [1:0] K_BBO = 2'd1;
    localparam logic [1:0] K_ADD = 2'd2;
    localparam logic [1:0] K_CXL = 2'd3;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_TICK = 2'd1;
    localparam logic [1:0] REG_VOLUME = 2'd2;

    localparam logic [2:0] ST_NEW = 3'd1;
    localparam logic [2:0] ST_ACKED = 3'd2;
    localparam logic [2:0] ST_PENDING_NEW = 3'd3;
    localparam logic [2:0] ST_PENDING_CANCEL = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;
    localparam logic [2:0] ST_NONE = 3'd6;

    localparam logic REQ_NEW = 1'b0;
    localparam logic REQ_CANCEL = 1'b1;
    localparam logic SIDE_BUY = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_BID, S_DIV_ASK, S_WAIT_ASK, S_DECIDE, S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start_bid;
        logic start_ask;
        logic decide;
        logic pop;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_theo;
        logic div_busy;
        logic has_req;
    } t_sts;
endpackage

FILE: sv/tsq_div.sv
`timescale 1ns / 1ps
module tsq_div
    import tsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PRICE_BITS:0]   i_num,
    input  logic [PRICE_BITS-1:0] i_den,
    output logic                  o_busy,
    output logic [PRICE_BITS-1:0] o_rem
);
    // restoring remainder, one quotient bit per cycle
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [PRICE_BITS:0] r_num, n_num;
    logic [PRICE_BITS:0] r_rem, n_rem;
    logic [PRICE_BITS+1:0] w_sh;

    always_comb begin
        n_cnt = r_cnt;
        n_num = r_num;
        n_rem = r_rem;
        w_sh = {r_rem, r_num[PRICE_BITS]};
        if (i_start) begin
            n_cnt = CNT_BITS'(PRICE_BITS + 1);
            n_num = i_num;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_num = {r_num[PRICE_BITS-1:0], 1'b0};
            if (w_sh >= {2'b00, i_den}) begin
                n_rem = (PRICE_BITS+1)'(w_sh - {2'b00, i_den});
            end else begin
                n_rem = w_sh[PRICE_BITS:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem = r_rem[PRICE_BITS-1:0];
endmodule

FILE: sv/tsq_ctrl.sv
`timescale 1ns / 1ps
module tsq_ctrl
    import tsq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = S_DIV_BID;
            S_DIV_BID: begin
                if (!i_sts.is_theo) n_state = S_DECIDE;
                else n_state = S_DIV_ASK;
            end
            S_DIV_ASK:  if (!i_sts.div_busy) n_state = S_WAIT_ASK;
            S_WAIT_ASK: if (!i_sts.div_busy) n_state = S_DECIDE;
            S_DECIDE:  n_state = S_EMIT;
            S_EMIT:    if (!i_sts.has_req) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load = i_valid;
            end
            S_DIV_BID: o_cmd.start_bid = 1'b1;
            S_DIV_ASK: o_cmd.start_ask = !i_sts.div_busy;
            S_DECIDE:  o_cmd.decide = 1'b1;
            S_EMIT: begin
                o_out_valid = i_sts.has_req;
                o_cmd.pop = i_sts.has_req && i_out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

FILE: sv/tsq_dp.sv
`timescale 1ns / 1ps
module tsq_dp
    import tsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [1:0]            i_kind,
    input  logic [PRICE_BITS-1:0] i_price_a,
    input  logic [PRICE_BITS-1:0] i_price_b,
    input  logic [ID_BITS-1:0]    i_order_id,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_request,
    output logic [ID_BITS-1:0]    o_out_order_id,
    output logic                  o_side,
    output logic [PRICE_BITS-1:0] o_out_price,
    output logic [VOL_BITS-1:0]   o_volume,
    output logic                  o_last
);
    localparam logic [PRICE_BITS:0] PMAX = {1'b0, {PRICE_BITS{1'b1}}};
    typedef logic [PRICE_BITS-1:0] t_price;

    logic [31:0] r_offset, r_tick;
    logic [VOL_BITS-1:0] r_vol;
    t_price r_mbid, r_mask, r_rbid, r_rask;
    logic [ID_BITS-1:0] r_sid [2];
    t_price r_sprice [2];
    logic [2:0] r_sst [2];
    logic [1:0] r_resend, r_caa;
    logic [ID_BITS-1:0] r_next;
    logic [1:0] r_kind;
    t_price r_pa;
    logic [ID_BITS-1:0] r_oid;
    t_price r_bid_rem;

    // request queue, up to six entries
    typedef struct packed {
        logic req;
        logic [ID_BITS-1:0] id;
        logic sd;
        t_price price;
        logic [VOL_BITS-1:0] vol;
    } t_req;
    t_req r_q [6];
    logic [2:0] r_qn, r_qh;

    t_price w_tick;
    logic [PRICE_BITS:0] w_d, w_sum, w_num;
    logic div_start, div_busy;
    t_price div_rem;

    assign w_tick = (r_tick == '0) ? t_price'(1) : t_price'(r_tick);
    assign w_d = {1'b0, r_pa} - {1'b0, t_price'(r_offset)};
    assign w_sum = {1'b0, r_pa} + {1'b0, t_price'(r_offset)};
    assign w_num = i_cmd.start_bid ? w_d : w_sum;
    assign div_start = i_cmd.start_bid || i_cmd.start_ask;

    tsq_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(w_num), .i_den(w_tick), .o_busy(div_busy), .o_rem(div_rem)
    );

    // decision logic, combinational, worked through in order over at most six requests
    t_price n_rbid, n_rask;
    logic [ID_BITS-1:0] n_sid [2];
    t_price n_sprice [2];
    logic [2:0] n_sst [2];
    logic [1:0] n_resend, n_caa;
    logic [ID_BITS-1:0] n_next;
    t_req n_q [6];
    logic [2:0] n_qn;
    t_price bid, ask;
    logic bid_free, ask_free;
    logic s;
    logic hit;
    logic [PRICE_BITS:0] base;

    function automatic t_req mk(input logic rq, input logic [ID_BITS-1:0] id,
                                input logic sd, input t_price p,
                                input logic [VOL_BITS-1:0] v);
        t_req x;
        x.req = rq; x.id = id; x.sd = sd; x.price = p; x.vol = v;
        return x;
    endfunction

    always_comb begin
        n_rbid = r_rbid; n_rask = r_rask;
        n_sid = r_sid; n_sprice = r_sprice; n_sst = r_sst;
        n_resend = r_resend; n_caa = r_caa; n_next = r_next;
        n_q = r_q; n_qn = '0;
        bid = '0; ask = '0; bid_free = 1'b1; ask_free = 1'b1;
        s = 1'b0; hit = 1'b0; base = '0;
        if (r_kind == K_THEO) begin
            if (r_pa == '0) begin
                if (n_rbid != '0) begin
                    n_q[n_qn] = mk(REQ_CANCEL, n_sid[0], SIDE_BUY, '0, '0);
                    n_qn = n_qn + 1'b1; n_sst[0] = ST_PENDING_CANCEL;
                end else if (n_sst[0] == ST_PENDING_NEW) n_caa[0] = 1'b1;
                if (n_rask != '0) begin
                    n_q[n_qn] = mk(REQ_CANCEL, n_sid[1], SIDE_SELL, '0, '0);
                    n_qn = n_qn + 1'b1; n_sst[1] = ST_PENDING_CANCEL;
                end else if (n_sst[1] == ST_PENDING_NEW) n_caa[1] = 1'b1;
            end else begin
                if (r_pa > t_price'(r_offset))
                    bid = t_price'(w_d) - r_bid_rem;
                if (w_sum <= PMAX) begin
                    if (div_rem == '0) ask = t_price'(w_sum);
                    else begin
                        base = w_sum - {1'b0, div_rem};
                        if (base <= PMAX - {1'b0, w_tick})
                            ask = t_price'(base + {1'b0, w_tick});
                    end
                end
                if (ask != '0 && !(n_rask != '0 && ask == r_mask) &&
                    !(n_rbid != '0 && ask < r_mbid)) begin
                    if (n_rask != '0) begin
                        ask_free = 1'b0;
                        n_q[n_qn] = mk(REQ_CANCEL, n_sid[1], SIDE_SELL, '0, '0);
                        n_qn = n_qn + 1'b1; n_sst[1] = ST_PENDING_CANCEL;
                    end
                    if (n_rbid != '0 && ask <= n_rbid) begin
                        bid_free = 1'b0;
                        n_q[n_qn] = mk(REQ_CANCEL, n_sid[0], SIDE_BUY, '0, '0);
                        n_qn = n_qn + 1'b1; n_sst[0] = ST_PENDING_CANCEL;
                    end
                    n_sprice[1] = ask;
                    if (ask_free) begin
                        if (r_mbid == '0 || ask > r_mbid) begin
                            ask_free = 1'b0;
                            n_next = n_next + 1'b1; n_sid[1] = n_next;
                            n_q[n_qn] = mk(REQ_NEW, n_next, SIDE_SELL, ask, r_vol);
                            n_qn = n_qn + 1'b1; n_sst[1] = ST_PENDING_NEW;
                        end
                    end else n_resend[1] = 1'b1;
                end
                if (bid != '0 && !(n_rbid != '0 && bid == r_mbid) &&
                    !(r_mask != '0 && bid > r_mask)) begin
                    if (n_rbid != '0) begin
                        n_q[n_qn] = mk(REQ_CANCEL, n_sid[0], SIDE_BUY, '0, '0);
                        n_qn = n_qn + 1'b1; n_sst[0] = ST_PENDING_CANCEL;
                        bid_free = 1'b0;
                    end
                    if (ask_free && n_rask != '0 && bid >= n_rask) begin
                        n_q[n_qn] = mk(REQ_CANCEL, n_sid[1], SIDE_SELL, '0, '0);
                        n_qn = n_qn + 1'b1; n_sst[1] = ST_PENDING_CANCEL;
                    end
                    n_sprice[0] = bid;
                    if (bid_free) begin
                        if (r_mask == '0 || bid < r_mask) begin
                            n_next = n_next + 1'b1; n_sid[0] = n_next;
                            n_q[n_qn] = mk(REQ_NEW, n_next, SIDE_BUY, bid, r_vol);
                            n_qn = n_qn + 1'b1; n_sst[0] = ST_PENDING_NEW;
                        end
                    end else n_resend[0] = 1'b1;
                end
            end
        end else if (r_kind == K_ADD || r_kind == K_CXL) begin
            if (r_sst[0] != ST_NONE && r_sid[0] == r_oid) begin
                hit = 1'b1; s = SIDE_BUY;
            end else if (r_sst[1] != ST_NONE && r_sid[1] == r_oid) begin
                hit = 1'b1; s = SIDE_SELL;
            end
            if (hit && r_kind == K_ADD) begin
                if (s == SIDE_BUY) n_rbid = r_sprice[0];
                else n_rask = r_sprice[1];
                n_sst[s] = ST_ACKED;
                if (r_caa[s]) begin
                    n_caa[s] = 1'b0;
                    n_q[0] = mk(REQ_CANCEL, r_sid[s], s, '0, '0);
                    n_qn = 3'd1; n_sst[s] = ST_PENDING_CANCEL;
                end
            end else if (hit) begin
                n_sst[s] = ST_DONE;
                if (s == SIDE_BUY) n_rbid = '0;
                else n_rask = '0;
                if (r_resend[s]) begin
                    if (s == SIDE_SELL) n_sst[1] = ST_NEW;
                    n_resend[s] = 1'b0;
                    if ((s == SIDE_BUY) ? (r_sprice[0] < r_mask)
                                        : (r_sprice[1] > r_mbid)) begin
                        n_next = r_next + 1'b1; n_sid[s] = n_next;
                        n_q[0] = mk(REQ_NEW, n_next, s, r_sprice[s], r_vol);
                        n_qn = 3'd1; n_sst[s] = ST_PENDING_NEW;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0; r_tick <= 32'd1; r_vol <= '0;
            r_mbid <= '0; r_mask <= '0; r_rbid <= '0; r_rask <= '0;
            r_sid[0] <= '0; r_sid[1] <= '0;
            r_sprice[0] <= '0; r_sprice[1] <= '0;
            r_sst[0] <= ST_NONE; r_sst[1] <= ST_NONE;
            r_resend <= '0; r_caa <= '0; r_next <= '0;
            r_qn <= '0; r_qh <= '0; r_kind <= K_THEO;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OFFSET: r_offset <= i_cfg_data;
                    REG_TICK:   r_tick <= i_cfg_data;
                    REG_VOLUME: r_vol <= i_cfg_data[VOL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_kind <= i_kind;
                if (i_kind == K_BBO) begin
                    r_mbid <= i_price_a; r_mask <= i_price_b;
                end
            end
            if (i_cmd.decide) begin
                r_rbid <= n_rbid; r_rask <= n_rask; r_sid <= n_sid;
                r_sprice <= n_sprice; r_sst <= n_sst; r_resend <= n_resend;
                r_caa <= n_caa; r_next <= n_next;
                r_qn <= n_qn; r_qh <= '0;
            end else if (i_cmd.pop) begin
                r_qh <= r_qh + 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_pa <= i_price_a; r_oid <= i_order_id;
        end
        if (i_cmd.decide) r_q <= n_q;
        if (i_cmd.start_ask) r_bid_rem <= div_rem;
    end

    assign o_sts.is_theo = (r_kind == K_THEO) && (r_pa != '0);
    assign o_sts.div_busy = div_busy;
    assign o_sts.has_req = r_qh < r_qn;
    assign o_request = r_q[r_qh].req;
    assign o_out_order_id = r_q[r_qh].id;
    assign o_side = r_q[r_qh].sd;
    assign o_out_price = r_q[r_qh].price;
    assign o_volume = r_q[r_qh].vol;
    assign o_last = (r_qh + 1'b1) == r_qn;
endmodule

FILE: sv/two_sided_quote_order_manager.sv
`timescale 1ns / 1ps
// sequence: a nonzero theo works out two tick remainders in turn, bid then ask, one bit
// per cycle, before the decide step; other events go straight from capture to decide;
// result beats then drain one per cycle while the receiver is ready
// flow: one event at a time; ready returns once the last result beat is taken and the
// sequencer is back in idle
// reset: synchronous active low; clears quotes, status and id counter; config to offset 0, tick 1, volume 0
module two_sided_quote_order_manager
    import tsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_kind,
    input  logic [PRICE_BITS-1:0] i_price_a,
    input  logic [PRICE_BITS-1:0] i_price_b,
    input  logic [ID_BITS-1:0]    i_order_id,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_request,
    output logic [ID_BITS-1:0]    o_out_order_id,
    output logic                  o_side,
    output logic [PRICE_BITS-1:0] o_out_price,
    output logic [VOL_BITS-1:0]   o_volume,
    output logic                  o_last
);
    t_cmd cmd;
    t_sts sts;

    // sequencer: capture, bid remainder, ask remainder (nonzero theo only), decide, drain beats
    tsq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_out_ready(i_ready), .o_out_valid(o_valid), .i_sts(sts), .o_cmd(cmd)
    );

    // quote state, tick divider and the result queue
    tsq_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .i_kind(i_kind),
        .i_price_a(i_price_a), .i_price_b(i_price_b), .i_order_id(i_order_id),
        .i_cmd(cmd), .o_sts(sts), .o_request(o_request),
        .o_out_order_id(o_out_order_id), .o_side(o_side),
        .o_out_price(o_out_price), .o_volume(o_volume), .o_last(o_last)
    );
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tsq_pkg::*;

    localparam longint unsigned PMASK = 64'hFFFF_FFFF;
    localparam int MAX_BEATS = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 120;

    // one request beat as the block presents it
    typedef struct packed {
        logic                  req;
        logic [ID_BITS-1:0]    id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [VOL_BITS-1:0]   vol;
        logic                  last;
    } order_req_t;

    // quote book predictor plus request checker
    class quote_scoreboard;
        longint unsigned offset, tick, vol;
        longint unsigned mkt_bid, mkt_ask, rest_bid, rest_ask;
        longint unsigned oid[2], px[2];
        logic [2:0]      status[2];
        bit              resend[2], cxl_on_ack[2];
        longint unsigned id_ctr;
        order_req_t      req_q[$];
        order_req_t      burst[$];
        logic [31:0]     add_ids[$];
        logic [31:0]     cxl_ids[$];
        int              errors;

        function void reset_book();
            offset = 0; tick = 1; vol = 0;
            mkt_bid = 0; mkt_ask = 0; rest_bid = 0; rest_ask = 0;
            oid[0] = 0; oid[1] = 0; px[0] = 0; px[1] = 0;
            status[0] = ST_NONE; status[1] = ST_NONE;
            resend = '{0, 0}; cxl_on_ack = '{0, 0};
            id_ctr = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_OFFSET: offset = val;
                REG_TICK:   tick = val;
                REG_VOLUME: vol = val[VOL_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void push_req(bit r, longint unsigned id, int s, longint unsigned p,
                               longint unsigned v);
            order_req_t b;
            if (burst.size() >= MAX_BEATS) return;
            b.req = r; b.id = id[31:0]; b.side = s[0]; b.price = p[31:0];
            b.vol = v[VOL_BITS-1:0]; b.last = 1'b0;
            burst.push_back(b);
        endfunction

        function void place_new(int s);
            id_ctr = (id_ctr + 1) & 64'hFFFF_FFFF;
            oid[s] = id_ctr;
            push_req(REQ_NEW, id_ctr, s, px[s], vol);
            add_ids.push_back(id_ctr[31:0]);
            status[s] = ST_PENDING_NEW;
        endfunction

        function void pull_quote(int s);
            push_req(REQ_CANCEL, oid[s], s, 0, 0);
            cxl_ids.push_back(oid[s][31:0]);
            status[s] = ST_PENDING_CANCEL;
        endfunction

        function int side_of(longint unsigned id);
            if (status[0] != ST_NONE && oid[0] == id) return 0;
            if (status[1] != ST_NONE && oid[1] == id) return 1;
            return -1;
        endfunction

        function void reprice(longint unsigned theo);
            longint unsigned t, bid, ask, sum, r, d;
            bit bid_free, ask_free;
            t = (tick != 0) ? tick : 1;
            bid = 0; ask = 0; bid_free = 1; ask_free = 1;
            // zero theo pulls both sides, deferred if the add is still in flight
            if (theo == 0) begin
                if (rest_bid != 0) pull_quote(SIDE_BUY);
                else if (status[0] == ST_PENDING_NEW) cxl_on_ack[0] = 1;
                if (rest_ask != 0) pull_quote(SIDE_SELL);
                else if (status[1] == ST_PENDING_NEW) cxl_on_ack[1] = 1;
                return;
            end
            if (theo > offset) begin
                d = theo - offset;
                bid = d - d % t;
            end
            sum = theo + offset;
            if (sum <= PMASK) begin
                r = sum % t;
                if (r == 0) ask = sum;
                else if (sum - r <= PMASK - t) ask = sum - r + t;
            end
            if (ask != 0 && !(rest_ask != 0 && ask == mkt_ask) &&
                !(rest_bid != 0 && ask < mkt_bid)) begin
                if (rest_ask != 0) begin
                    ask_free = 0;
                    pull_quote(SIDE_SELL);
                end
                if (rest_bid != 0 && ask <= rest_bid) begin
                    bid_free = 0;
                    pull_quote(SIDE_BUY);
                end
                px[1] = ask;
                if (ask_free) begin
                    if (mkt_bid == 0 || ask > mkt_bid) begin
                        ask_free = 0;
                        place_new(SIDE_SELL);
                    end
                end else begin
                    resend[1] = 1;
                end
            end
            if (bid != 0 && !(rest_bid != 0 && bid == mkt_bid) &&
                !(mkt_ask != 0 && bid > mkt_ask)) begin
                if (rest_bid != 0) begin
                    pull_quote(SIDE_BUY);
                    bid_free = 0;
                end
                if (ask_free && rest_ask != 0 && bid >= rest_ask) pull_quote(SIDE_SELL);
                px[0] = bid;
                if (bid_free) begin
                    if (mkt_ask == 0 || bid < mkt_ask) place_new(SIDE_BUY);
                end else begin
                    resend[0] = 1;
                end
            end
        endfunction

        function void add_acked(longint unsigned id);
            int s;
            s = side_of(id);
            if (s < 0) return;
            if (s == 0) rest_bid = px[0];
            else rest_ask = px[1];
            status[s] = ST_ACKED;
            if (cxl_on_ack[s]) begin
                cxl_on_ack[s] = 0;
                pull_quote(s);
            end
        endfunction

        function void cxl_acked(longint unsigned id);
            int s;
            s = side_of(id);
            if (s < 0) return;
            status[s] = ST_DONE;
            if (s == 0) begin
                rest_bid = 0;
                if (resend[0]) begin
                    resend[0] = 0;
                    if (px[0] < mkt_ask) place_new(SIDE_BUY);
                end
            end else begin
                rest_ask = 0;
                if (resend[1]) begin
                    status[1] = ST_NEW;
                    resend[1] = 0;
                    if (px[1] > mkt_bid) place_new(SIDE_SELL);
                end
            end
        endfunction

        // accepted input beat: work out the requests it causes
        function void note_event(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
                                 logic [31:0] id);
            burst.delete();
            case (kind)
                K_THEO: reprice(a);
                K_BBO: begin
                    mkt_bid = a;
                    mkt_ask = b;
                end
                K_ADD: add_acked(id);
                default: cxl_acked(id);
            endcase
            if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
            foreach (burst[i]) req_q.push_back(burst[i]);
        endfunction

        function void check_beat(order_req_t got);
            order_req_t want;
            if (req_q.size() == 0) begin
                $display("%0t: unexpected request beat, got %h", $time, got);
                errors++;
                return;
            end
            want = req_q.pop_front();
            if (got.req !== want.req)
                $display("%0t: request exp %0d got %0d", $time, want.req, got.req);
            if (got.id !== want.id)
                $display("%0t: order id exp %0d got %0d", $time, want.id, got.id);
            if (got.side !== want.side)
                $display("%0t: side exp %0d got %0d", $time, want.side, got.side);
            if (got.price !== want.price)
                $display("%0t: price exp %0d got %0d", $time, want.price, got.price);
            if (got.vol !== want.vol)
                $display("%0t: volume exp %0d got %0d", $time, want.vol, got.vol);
            if (got.last !== want.last)
                $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
            if (got !== want) errors++;
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [1:0]            i_cfg_index = '0;
    logic [31:0]           i_cfg_data = '0;
    logic                  i_valid = 0;
    logic                  o_ready;
    logic [1:0]            i_kind = K_BBO;
    logic [PRICE_BITS-1:0] i_price_a = '0;
    logic [PRICE_BITS-1:0] i_price_b = '0;
    logic [ID_BITS-1:0]    i_order_id = '0;
    logic                  o_valid;
    logic                  i_ready = 0;
    logic                  o_request;
    logic [ID_BITS-1:0]    o_out_order_id;
    logic                  o_side;
    logic [PRICE_BITS-1:0] o_out_price;
    logic [VOL_BITS-1:0]   o_volume;
    logic                  o_last;

    quote_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_off = 0;

    two_sided_quote_order_manager u_top (.*);

    always #1 i_clk = ~i_clk;

    // acceptance monitor and request beat checker, sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_event(i_kind, i_price_a, i_price_b, i_order_id);
            if (o_valid && i_ready)
                sb.check_beat({o_request, o_out_order_id, o_side, o_out_price,
                               o_volume, o_last});
        end
    end

    // watchdog on cycles with no beat moving on either side and no config write
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // request receiver with random back-pressure and one long hold-off
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold_off = 0;
                i_ready = 0;
                repeat (400) @(negedge i_clk);
            end
            g = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
            if ($urandom_range(9) < 3) g = 0;
            if (g > 0) begin
                i_ready = 0;
                repeat (g) @(negedge i_clk);
            end
            i_ready = 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_event(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
                              logic [31:0] id);
        int g;
        g = $urandom_range(19);
        if ($urandom_range(9) < 3) g = 0;
        if (g > 0) begin
            i_valid = 0;
            repeat (g) @(negedge i_clk);
        end
        i_valid = 1;
        i_kind = kind;
        i_price_a = a;
        i_price_b = b;
        i_order_id = id;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // wait out every pending request before touching the config
    task automatic settle();
        i_valid = 0;
        while (sb.req_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic load_cfg(logic [31:0] off, logic [31:0] tk, logic [31:0] v);
        settle();
        write_reg(REG_OFFSET, off);
        write_reg(REG_TICK, tk);
        write_reg(REG_VOLUME, v);
    endtask

    // acks mostly target ids the block has really issued
    task automatic ack_add(bit known);
        int k;
        logic [31:0] id;
        id = $urandom;
        if (known && sb.add_ids.size() > 0) begin
            k = $urandom_range(sb.add_ids.size() - 1);
            id = sb.add_ids[k];
            sb.add_ids.delete(k);
        end
        send_event(K_ADD, $urandom, $urandom, id);
    endtask

    task automatic ack_cxl(bit known);
        int k;
        logic [31:0] id;
        id = $urandom;
        if (known && sb.cxl_ids.size() > 0) begin
            k = $urandom_range(sb.cxl_ids.size() - 1);
            id = sb.cxl_ids[k];
            sb.cxl_ids.delete(k);
        end
        send_event(K_CXL, $urandom, $urandom, id);
    endtask

    task automatic random_event();
        int p;
        logic [31:0] a, b;
        p = $urandom_range(99);
        if (p < 35) begin
            case ($urandom_range(19))
                0, 1:    a = 0;
                2:       a = $urandom;
                3:       a = 32'hFFFF_FFFF - $urandom_range(2000);
                default: a = 100000 + $urandom_range(20000);
            endcase
            send_event(K_THEO, a, $urandom, $urandom);
        end else if (p < 50) begin
            case ($urandom_range(9))
                0: begin a = 0; b = 0; end
                1: begin a = $urandom; b = $urandom; end
                default: begin
                    a = 100000 + $urandom_range(20000);
                    b = a + $urandom_range(3000);
                end
            endcase
            send_event(K_BBO, a, b, $urandom);
        end else if (p < 72) ack_add(p < 69);
        else if (p < 94) ack_cxl(p < 91);
        else send_event(2'($urandom_range(3)), $urandom, $urandom, $urandom);
    endtask

    initial begin
        int n;
        sb.reset_book();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        // directed: quote, ack, reprice through cancel and resend, pulls
        load_cfg(250, 100, 1000);
        send_event(K_BBO, 9000, 11000, 0);
        send_event(K_THEO, 10000, 0, 0);
        ack_add(1); ack_add(1);
        send_event(K_THEO, 10500, 0, 0);
        send_event(K_THEO, 10500, 0, 0);
        ack_cxl(1); ack_cxl(1);
        ack_add(1); ack_add(1);
        send_event(K_THEO, 0, 0, 0);
        ack_cxl(1); ack_cxl(1);
        // zero theo while adds are still in flight
        send_event(K_THEO, 10200, 0, 0);
        send_event(K_THEO, 0, 0, 0);
        ack_add(1); ack_add(1);
        ack_cxl(1); ack_cxl(1);
        // bid below zero, ask past the top of range, unknown ids
        send_event(K_THEO, 100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(K_THEO, 32'hFFFF_FFFF, 0, 0);
        send_event(K_ADD, 0, 0, 32'hFFFF_FFFF);
        send_event(K_CXL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
        send_event(K_BBO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

        // random phases over a range of settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: load_cfg(0, 1, 0);
                1: load_cfg($urandom_range(3000), $urandom_range(1, 1000), $urandom);
                2: load_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF);
                3: load_cfg($urandom_range(500), 0, 1);
                default: load_cfg(150, 50, $urandom_range(16777215));
            endcase
            n = (ph == 2) ? 30 : 60;
            for (int i = 0; i < n; i++) begin
                if (ph == 1 && i == 20) hold_off = 1;
                random_event();
            end
        end

        settle();
        if (sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: files.f
sv/tsq_pkg.sv
sv/tsq_div.sv
sv/tsq_ctrl.sv
sv/tsq_dp.sv
sv/two_sided_quote_order_manager.sv
dv/tb_top.sv
